@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level file to check its own logic
// clk and rst must be in scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DSPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define DSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dspe_pkg.sv @@
`timescale 1ns / 1ps

package dspe_pkg;

  // graph size and widths
  localparam int MAX_VERTICES = 16;
  localparam int VTX_BITS     = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = VTX_BITS + 1;
  localparam int ADDR_BITS    = 2 * VTX_BITS;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 21;
  localparam int LEN_BITS     = 20;
  localparam int CFG_BITS     = 5;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_SAT = DIST_INF - DIST_BITS'(1);
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
  localparam logic [CFG_BITS-1:0]  VCOUNT_RESET = CFG_BITS'(16);

  // item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_MARK,
    ST_RELAX_RD,
    ST_RELAX_WR,
    ST_EMIT
  } dspe_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic run_start;
    logic pick;
    logic mark;
    logic relax_rd;
    logic relax_wr;
    logic emit;
  } dspe_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic                scan_last;
    logic                single_vertex;
    logic                u_unreached;
    logic                rounds_one;
    logic                rounds_zero;
    logic                out_free;
    logic [VTX_BITS-1:0] vertex_last;
  } dspe_sts_t;

endpackage

@@ hdl/dspe_in_if.sv @@
`timescale 1ns / 1ps

interface dspe_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [3:0]                         row_vertex;
  logic [3:0]                         col_vertex;
  logic [dspe_pkg::WEIGHT_BITS-1:0]   edge_weight;
  logic [3:0]                         source_vertex;

  modport source (output valid, op, row_vertex, col_vertex, edge_weight, source_vertex,
                  input ready);
  modport sink   (input valid, op, row_vertex, col_vertex, edge_weight, source_vertex,
                  output ready);
endinterface

@@ hdl/dspe_out_if.sv @@
`timescale 1ns / 1ps

interface dspe_out_if;
  logic                            valid;
  logic                            ready;
  logic [3:0]                      vertex_id;
  logic [dspe_pkg::LEN_BITS-1:0]   path_length;
  logic                            unreachable;
  logic                            last_result;

  modport source (output valid, vertex_id, path_length, unreachable, last_result,
                  input ready);
  modport sink   (input valid, vertex_id, path_length, unreachable, last_result,
                  output ready);
endinterface

@@ hdl/dspe_ctrl.sv @@
`timescale 1ns / 1ps

module dspe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  dspe_pkg::dspe_sts_t sts,
  output dspe_pkg::dspe_cmd_t cmd
);

  dspe_pkg::dspe_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dspe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dspe_pkg::ST_IDLE: begin
        if (in_valid && in_op == dspe_pkg::OP_RUN) begin
          state_next = sts.single_vertex ? dspe_pkg::ST_EMIT : dspe_pkg::ST_PICK;
        end
      end
      dspe_pkg::ST_PICK: begin
        if (sts.scan_last) state_next = dspe_pkg::ST_MARK;
      end
      dspe_pkg::ST_MARK: begin
        if (sts.u_unreached) begin
          state_next = sts.rounds_one ? dspe_pkg::ST_EMIT : dspe_pkg::ST_PICK;
        end else begin
          state_next = dspe_pkg::ST_RELAX_RD;
        end
      end
      dspe_pkg::ST_RELAX_RD: state_next = dspe_pkg::ST_RELAX_WR;
      dspe_pkg::ST_RELAX_WR: begin
        if (sts.scan_last) begin
          state_next = sts.rounds_zero ? dspe_pkg::ST_EMIT : dspe_pkg::ST_PICK;
        end else begin
          state_next = dspe_pkg::ST_RELAX_RD;
        end
      end
      dspe_pkg::ST_EMIT: begin
        if (sts.out_free && sts.scan_last) state_next = dspe_pkg::ST_IDLE;
      end
      default: state_next = dspe_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dspe_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load      = in_valid && in_op == dspe_pkg::OP_LOAD;
        cmd.run_start = in_valid && in_op == dspe_pkg::OP_RUN;
      end
      dspe_pkg::ST_PICK:     cmd.pick     = 1'b1;
      dspe_pkg::ST_MARK:     cmd.mark     = 1'b1;
      dspe_pkg::ST_RELAX_RD: cmd.relax_rd = 1'b1;
      dspe_pkg::ST_RELAX_WR: cmd.relax_wr = 1'b1;
      dspe_pkg::ST_EMIT:     cmd.emit     = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/dspe_datapath.sv @@
`timescale 1ns / 1ps

module dspe_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dspe_pkg::dspe_cmd_t                 cmd,
  output dspe_pkg::dspe_sts_t                 sts,
  input  logic                                cfg_wr_en,
  input  logic [dspe_pkg::CFG_BITS-1:0]       cfg_wr_data,
  input  logic [3:0]                          row_vertex,
  input  logic [3:0]                          col_vertex,
  input  logic [dspe_pkg::WEIGHT_BITS-1:0]    edge_weight,
  input  logic [3:0]                          source_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3:0]                          vertex_id,
  output logic [dspe_pkg::LEN_BITS-1:0]       path_length,
  output logic                                unreachable,
  output logic                                last_result
);

  localparam int VB = dspe_pkg::VTX_BITS;
  localparam int CB = dspe_pkg::CNT_BITS;
  localparam int DB = dspe_pkg::DIST_BITS;
  localparam int WB = dspe_pkg::WEIGHT_BITS;

  logic [dspe_pkg::CFG_BITS-1:0]  vertex_count;
  logic [CB-1:0]                  n_used;
  logic [VB-1:0]                  idx;
  logic [VB-1:0]                  idx_next;
  logic                           scan_last;
  logic [CB-1:0]                  rounds;
  logic [DB-1:0]                  dist_tbl [dspe_pkg::MAX_VERTICES];
  logic [dspe_pkg::MAX_VERTICES-1:0] visited;
  logic [DB-1:0]                  best;
  logic [DB-1:0]                  pick_base;
  logic [VB-1:0]                  at;
  logic [VB-1:0]                  u_vtx;
  logic [DB-1:0]                  dist_u;
  logic [WB-1:0]                  weight_mem [2**dspe_pkg::ADDR_BITS];
  logic [WB-1:0]                  weight_q;
  logic [DB:0]                    relax_sum;
  logic [DB-1:0]                  relax_sat;
  logic [DB-1:0]                  dist_cur;
  logic                           out_free;

  // vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dspe_pkg::VCOUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // vertices in use, clamped to one..max
  always_comb begin
    if (vertex_count == '0) begin
      n_used = CB'(1);
    end else if (CB'(vertex_count) > CB'(dspe_pkg::MAX_VERTICES)) begin
      n_used = CB'(dspe_pkg::MAX_VERTICES);
    end else begin
      n_used = CB'(vertex_count);
    end
  end

  // vertex scan counter, wraps after the last vertex in use
  assign scan_last = ({1'b0, idx} == n_used - CB'(1));
  assign idx_next  = scan_last ? '0 : idx + VB'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.run_start) begin
      idx <= '0;
    end else if (cmd.pick || cmd.relax_wr || cmd.emit) begin
      idx <= idx_next;
    end
  end

  // rounds still to do
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= '0;
    end else if (cmd.run_start) begin
      rounds <= n_used - CB'(1);
    end else if (cmd.mark) begin
      rounds <= rounds - CB'(1);
    end
  end

  // weight matrix, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      weight_mem[{row_vertex[VB-1:0], col_vertex[VB-1:0]}] <= edge_weight;
    end
    if (cmd.relax_rd) begin
      weight_q <= weight_mem[{u_vtx, idx}];
    end
  end

  assign dist_cur = dist_tbl[idx];

  // minimum search, first step starts from infinity
  assign pick_base = (idx == '0) ? dspe_pkg::DIST_INF : best;

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      if (!visited[idx] && dist_cur <= pick_base) begin
        best <= dist_cur;
        at   <= idx;
      end else if (idx == '0) begin
        best <= dspe_pkg::DIST_INF;
        at   <= '0;
      end
    end
    if (cmd.mark) begin
      u_vtx  <= at;
      dist_u <= best;
    end
  end

  // relaxation sum with saturation below infinity
  assign relax_sum = {1'b0, dist_u} + (DB + 1)'(weight_q);
  assign relax_sat = (relax_sum > {1'b0, dspe_pkg::DIST_SAT}) ? dspe_pkg::DIST_SAT
                                                             : relax_sum[DB-1:0];

  // distance table and visited flags
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      for (int i = 0; i < dspe_pkg::MAX_VERTICES; i++) begin
        dist_tbl[i] <= dspe_pkg::DIST_INF;
      end
      if ({1'b0, source_vertex[VB-1:0]} < n_used) begin
        dist_tbl[source_vertex[VB-1:0]] <= '0;
      end
    end else if (cmd.relax_wr) begin
      if (!visited[idx] && weight_q != '0 && relax_sat < dist_cur) begin
        dist_tbl[idx] <= relax_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (cmd.run_start) begin
      visited <= '0;
    end else if (cmd.mark) begin
      visited[at] <= 1'b1;
    end
  end

  // result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      vertex_id   <= 4'(idx);
      unreachable <= (dist_cur == dspe_pkg::DIST_INF);
      last_result <= scan_last;
      if (dist_cur == dspe_pkg::DIST_INF) begin
        path_length <= '0;
      end else if (dist_cur > {1'b0, dspe_pkg::LEN_MAX}) begin
        path_length <= dspe_pkg::LEN_MAX;
      end else begin
        path_length <= dist_cur[dspe_pkg::LEN_BITS-1:0];
      end
    end
  end

  // status to controller
  always_comb begin
    sts               = '0;
    sts.scan_last     = scan_last;
    sts.single_vertex = (n_used == CB'(1));
    sts.u_unreached   = (best == dspe_pkg::DIST_INF);
    sts.rounds_one    = (rounds == CB'(1));
    sts.rounds_zero   = (rounds == '0);
    sts.out_free      = out_free;
    sts.vertex_last   = VB'(n_used - CB'(1));
  end

endmodule

@@ hdl/dense_shortest_path_engine_top.sv @@
// load item: accepted while idle, one per cycle back to back
// run item: n-1 rounds of a minimum scan over n vertices, a mark and a relaxation
// (read then write per vertex, as the matrix read is registered; skipped for an
// unreached pick), then n result beats; input is held off until the last beat is loaded
// reset (rst, synchronous): controller idle, output empty, vertex_count 16;
// the weight matrix is not cleared and holds whatever was last written
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dense_shortest_path_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  dspe_in_if.sink                       in_ch,
  dspe_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [dspe_pkg::CFG_BITS-1:0] cfg_wr_data
);

  dspe_pkg::dspe_cmd_t cmd;
  dspe_pkg::dspe_sts_t sts;

  // sequencer
  dspe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // matrix, distance table and result register
  dspe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .row_vertex    (in_ch.row_vertex),
    .col_vertex    (in_ch.col_vertex),
    .edge_weight   (in_ch.edge_weight),
    .source_vertex (in_ch.source_vertex),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .vertex_id     (out_ch.vertex_id),
    .path_length   (out_ch.path_length),
    .unreachable   (out_ch.unreachable),
    .last_result   (out_ch.last_result)
  );

  // checks
  `DSPE_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
  `DSPE_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "result written over a held beat")
  `DSPE_ASSERT_SAME(a_last_id, out_ch.valid && out_ch.last_result,
    out_ch.vertex_id == sts.vertex_last, "last marker on the wrong vertex")
  `DSPE_ASSERT_NEXT(a_run_busy, in_ch.valid && in_ch.ready && in_ch.op == dspe_pkg::OP_RUN,
    !in_ch.ready, "input taken while a run is in progress")

endmodule
